/* rtl/core/ppid_pkg.sv */
// Package for the position PID controller with speed feedforward.
// Holds field widths, limits, scaling constants and register indexes.
// No dependencies.
`default_nettype none

package ppid_pkg;

  // Beat field widths
  localparam int unsigned POS_W   = 31;
  localparam int unsigned SPEED_W = 13;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned GAIN_W  = 15;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned ACC_W   = 29;

  // APB side
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;

  // Scaling and limits
  localparam int P_LIMIT   = 3500;
  localparam int I_LIMIT   = 5000 * 32768;
  localparam int DIR_BIAS  = 750;
  localparam int D_SCALE   = 1000;
  localparam int P_SHIFT   = 4;
  localparam int I_SHIFT   = 15;
  localparam int DSCALED_W = 25;

  localparam logic signed [DRIVE_W-1:0] OUT_UPPER_RST = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] OUT_LOWER_RST = 16'sh8000;

  // Register map, by word index
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_UPPER  = 3'd3,
    REG_OUT_LOWER  = 3'd4
  } reg_idx_t;

endpackage : ppid_pkg

`default_nettype wire

/* rtl/core/position_pid_with_speed_feedforward.sv */
// Top level of the position PID controller with speed feedforward.
// Five-register pipeline with APB configuration; uses ppid_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | sink      | in_valid / in_stall | in_target_pos, in_measured_pos, in_speed_ref
//   out     | source    | out_valid/out_stall | out_drive_out
//   apb     | slave     | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One beat per clock is accepted while in_stall is low; each result passes through the
// input register, error, products, integral and partial sum, and output register
// before out_valid rises.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles
// collapse and a new beat is taken while a finished result waits at the output.
// Synchronous active-low reset empties the pipeline, zeroes the error and
// integral state and restores the register defaults. No clearing pass.
`default_nettype none

module position_pid_with_speed_feedforward (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel
  input  wire logic                                   in_valid,
  output      logic                                   in_stall,
  input  wire logic signed [ppid_pkg::POS_W-1:0]      in_target_pos,
  input  wire logic signed [ppid_pkg::POS_W-1:0]      in_measured_pos,
  input  wire logic signed [ppid_pkg::SPEED_W-1:0]    in_speed_ref,
  // Result channel
  output      logic                                   out_valid,
  input  wire logic                                   out_stall,
  output      logic signed [ppid_pkg::DRIVE_W-1:0]    out_drive_out,
  // Configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [ppid_pkg::APB_AW-1:0]            paddr,
  input  wire logic [ppid_pkg::APB_DW-1:0]            pwdata,
  output      logic [ppid_pkg::APB_DW-1:0]            prdata,
  output      logic                                   pready
);

  import ppid_pkg::*;

  localparam int unsigned PPROD_W = ERR_W + GAIN_W + 1;         // 48
  localparam int unsigned P_W     = 13;
  localparam int unsigned DIFF_W  = ERR_W + 1;                  // 33
  localparam int unsigned DPROD_W = DIFF_W + DSCALED_W + 1;     // 59
  localparam int unsigned IERR_W  = ERR_W - P_SHIFT;            // 28
  localparam int unsigned IPROD_W = IERR_W + GAIN_W + 1;        // 44
  localparam int unsigned ASUM_W  = IPROD_W + 1;                // 45
  localparam int unsigned ITERM_W = ACC_W - I_SHIFT;            // 14
  localparam int unsigned FF_W    = SPEED_W + 5;                // 18
  localparam int unsigned PDF_W   = DPROD_W + 1;                // 60
  localparam int unsigned SUM_W   = PDF_W + 1;                  // 61

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]               prop_gain_r;
  logic [GAIN_W-1:0]               integ_gain_r;
  logic [GAIN_W-1:0]               deriv_gain_r;
  logic [DSCALED_W-1:0]            deriv_scaled_r;
  logic signed [DRIVE_W-1:0]       out_upper_r;
  logic signed [DRIVE_W-1:0]       out_lower_r;
  logic                            cfg_wr;
  reg_idx_t                        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  // Write a register; keep the derivative gain pre-scaled by 1000
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      deriv_gain_r   <= '0;
      deriv_scaled_r <= '0;
      out_upper_r    <= OUT_UPPER_RST;
      out_lower_r    <= OUT_LOWER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: begin
          deriv_gain_r   <= pwdata[GAIN_W-1:0];
          deriv_scaled_r <= DSCALED_W'(pwdata[GAIN_W-1:0]) * DSCALED_W'(D_SCALE);
        end
        REG_OUT_UPPER:  out_upper_r  <= pwdata[DRIVE_W-1:0];
        REG_OUT_LOWER:  out_lower_r  <= pwdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  prdata = APB_DW'(prop_gain_r);
      REG_INTEG_GAIN: prdata = APB_DW'(integ_gain_r);
      REG_DERIV_GAIN: prdata = APB_DW'(deriv_gain_r);
      REG_OUT_UPPER:  prdata = {{(APB_DW-DRIVE_W){out_upper_r[DRIVE_W-1]}}, out_upper_r};
      REG_OUT_LOWER:  prdata = {{(APB_DW-DRIVE_W){out_lower_r[DRIVE_W-1]}}, out_lower_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic en0, en1, en2, en3, en4;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_stall  = !en0;
  assign out_valid = v4_r;

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0]   s0_target_r;
  logic signed [POS_W-1:0]   s0_meas_r;
  logic signed [SPEED_W-1:0] s0_speed_r;

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      s0_target_r <= in_target_pos;
      s0_meas_r   <= in_measured_pos;
      s0_speed_r  <= in_speed_ref;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: position error
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [ERR_W-1:0]   s1_err_r;
  logic signed [SPEED_W-1:0] s1_speed_r;

  assign err_nxt = $signed({s0_target_r[POS_W-1], s0_target_r})
                 - $signed({s0_meas_r[POS_W-1], s0_meas_r});

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      s1_err_r   <= err_nxt;
      s1_speed_r <= s0_speed_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain products, sign-change test, feedforward
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]   prev_error_r;
  logic signed [PPROD_W-1:0] p_prod;
  logic signed [PPROD_W-1:0] p_shr;
  logic signed [P_W-1:0]     p_nxt;
  logic signed [DIFF_W-1:0]  err_diff;
  logic signed [DPROD_W-1:0] d_nxt;
  logic signed [IERR_W-1:0]  err_shr;
  logic signed [IPROD_W-1:0] i_prod_nxt;
  logic                      clr_nxt;
  logic signed [FF_W-1:0]    spd_ext;
  logic signed [FF_W-1:0]    spd_x15;
  logic signed [FF_W-1:0]    spd_half;
  logic signed [FF_W-1:0]    bias;
  logic signed [FF_W-1:0]    ff_nxt;

  logic signed [P_W-1:0]     s2_p_r;
  logic signed [DPROD_W-1:0] s2_d_r;
  logic signed [IPROD_W-1:0] s2_i_prod_r;
  logic                      s2_clr_r;
  logic signed [FF_W-1:0]    s2_ff_r;

  // Proportional term, clamped
  assign p_prod = $signed({1'b0, prop_gain_r}) * s1_err_r;
  assign p_shr  = p_prod >>> P_SHIFT;

  always_comb begin
    if (p_shr > PPROD_W'(P_LIMIT)) begin
      p_nxt = P_W'(P_LIMIT);
    end else if (p_shr < PPROD_W'(-P_LIMIT)) begin
      p_nxt = P_W'(-P_LIMIT);
    end else begin
      p_nxt = p_shr[P_W-1:0];
    end
  end

  // Derivative term from the error step
  assign err_diff = $signed({s1_err_r[ERR_W-1], s1_err_r})
                  - $signed({prev_error_r[ERR_W-1], prev_error_r});
  assign d_nxt    = $signed({1'b0, deriv_scaled_r}) * err_diff;

  // Integral increment and reset on a sign change
  assign err_shr    = IERR_W'(s1_err_r >>> P_SHIFT);
  assign i_prod_nxt = $signed({1'b0, integ_gain_r}) * err_shr;
  assign clr_nxt    = (s1_err_r < 0 && prev_error_r > 0)
                   || (s1_err_r > 0 && prev_error_r < 0);

  // Speed feedforward with direction bias
  assign spd_ext  = FF_W'(s1_speed_r);
  assign spd_x15  = (spd_ext <<< 4) - spd_ext;
  assign spd_half = spd_x15 >>> 1;

  always_comb begin
    if (s1_speed_r > 0) begin
      bias = FF_W'(DIR_BIAS);
    end else if (s1_speed_r < 0) begin
      bias = FF_W'(-DIR_BIAS);
    end else begin
      bias = '0;
    end
  end

  assign ff_nxt = spd_half + bias;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      s2_p_r      <= p_nxt;
      s2_d_r      <= d_nxt;
      s2_i_prod_r <= i_prod_nxt;
      s2_clr_r    <= clr_nxt;
      s2_ff_r     <= ff_nxt;
    end
  end

  // Hold the previous error as each beat leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
    end else if (en2 && v1_r) begin
      prev_error_r <= s1_err_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: integral update, partial sum
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]   integ_acc_r;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ASUM_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [PDF_W-1:0]   pdf_nxt;
  logic signed [PDF_W-1:0]   s3_pdf_r;
  logic signed [ITERM_W-1:0] s3_iterm_r;

  assign acc_base = s2_clr_r ? '0 : integ_acc_r;
  assign acc_sum  = ASUM_W'(acc_base) + ASUM_W'(s2_i_prod_r);

  always_comb begin
    if (acc_sum > ASUM_W'(I_LIMIT)) begin
      acc_nxt = ACC_W'(I_LIMIT);
    end else if (acc_sum < ASUM_W'(-I_LIMIT)) begin
      acc_nxt = ACC_W'(-I_LIMIT);
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  assign acc_shr = acc_nxt >>> I_SHIFT;
  assign pdf_nxt = PDF_W'(s2_p_r) + PDF_W'(s2_d_r) + PDF_W'(s2_ff_r);

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      s3_pdf_r   <= pdf_nxt;
      s3_iterm_r <= acc_shr[ITERM_W-1:0];
    end
  end

  // Advance the integral as each beat leaves stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r <= '0;
    end else if (en3 && v2_r) begin
      integ_acc_r <= acc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final sum, output clamp, result register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]   sum;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic signed [DRIVE_W-1:0] drive_r;

  assign sum = SUM_W'(s3_pdf_r) + SUM_W'(s3_iterm_r);

  // Upper limit wins when the limits are inverted
  always_comb begin
    if (sum > SUM_W'(out_upper_r)) begin
      drive_nxt = out_upper_r;
    end else if (sum < SUM_W'(out_lower_r)) begin
      drive_nxt = out_lower_r;
    end else begin
      drive_nxt = sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_drive_out = drive_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    integ_acc_r <= ACC_W'(I_LIMIT) && integ_acc_r >= ACC_W'(-I_LIMIT))
    else $error("integral left its clamp range");

  a_p_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (s2_p_r <= P_W'(P_LIMIT) && s2_p_r >= P_W'(-P_LIMIT)))
    else $error("proportional term left its clamp range");

  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lower_r <= out_upper_r)
      |-> (out_drive_out <= out_upper_r && out_drive_out >= out_lower_r))
    else $error("drive outside configured limits");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_state_moves_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(en2 && v1_r) |=> $stable(prev_error_r))
    else $error("previous error changed without a beat leaving stage 1");

endmodule : position_pid_with_speed_feedforward

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for position_pid_with_speed_feedforward. It drives control ticks with random
// gaps and output stalls, predicts each drive value and checks the results in order.
// Depends on ppid_pkg and the controller RTL only.

module tb;
  import ppid_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_CAP    = 40;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned GAP_MAX      = 19;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BEATS  = 250;
  localparam int unsigned CHUNK_BEATS  = 50;

  // Controller arithmetic, kept apart from the package on purpose
  localparam longint PROP_CLAMP  = 3500;
  localparam longint INTEG_CLAMP = 5000 * 32768;
  localparam longint DIR_OFFSET  = 750;
  localparam longint FF_GAIN     = 15;
  localparam longint DERIV_SCALE = 1000;
  localparam int     PROP_SHIFT  = 4;
  localparam int     ERR_SHIFT   = 4;
  localparam int     INTEG_SHIFT = 15;
  localparam longint WALK_MAX    = 1 << 24;

  // Highest word index that paddr can reach; indexes past REG_OUT_LOWER are unmapped
  localparam logic [2:0] REG_SLOT_LAST = 3'd7;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [POS_W-1:0]     in_target_pos;
  logic signed [POS_W-1:0]     in_measured_pos;
  logic signed [SPEED_W-1:0]   in_speed_ref;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [DRIVE_W-1:0]   out_drive_out;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [APB_AW-1:0]           paddr;
  logic [APB_DW-1:0]           pwdata;
  logic [APB_DW-1:0]           prdata;
  logic                        pready;

  // Predictor copy of the registers and the loop state
  logic [GAIN_W-1:0]           kp = '0;
  logic [GAIN_W-1:0]           ki = '0;
  logic [GAIN_W-1:0]           kd = '0;
  logic signed [DRIVE_W-1:0]   drive_hi = 16'sh7FFF;
  logic signed [DRIVE_W-1:0]   drive_lo = 16'sh8000;
  longint                      last_err = 0;
  longint                      integ_sum = 0;

  logic signed [DRIVE_W-1:0]   pending_drive[$];
  int unsigned                 mismatch_count = 0;
  int unsigned                 cycle_count = 0;
  bit                          no_idle = 1'b0;

  position_pid_with_speed_feedforward i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_pos   (in_target_pos),
    .in_measured_pos (in_measured_pos),
    .in_speed_ref    (in_speed_ref),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_out   (out_drive_out),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the loop state by one tick and return the drive value it gives
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
      input logic signed [POS_W-1:0] tgt, meas, input logic signed [SPEED_W-1:0] spd);
    longint err;
    longint prop;
    longint deriv;
    longint ff;
    longint total;
    err = longint'(tgt) - longint'(meas);

    prop = (longint'(kp) * err) >>> PROP_SHIFT;
    if (prop > PROP_CLAMP) prop = PROP_CLAMP;
    if (prop < -PROP_CLAMP) prop = -PROP_CLAMP;

    deriv = longint'(kd) * (err - last_err) * DERIV_SCALE;

    // clear the integral on a change of error sign, then accumulate and clamp
    if ((err < 0 && last_err > 0) || (err > 0 && last_err < 0)) integ_sum = 0;
    integ_sum = integ_sum + longint'(ki) * (err >>> ERR_SHIFT);
    if (integ_sum > INTEG_CLAMP) integ_sum = INTEG_CLAMP;
    if (integ_sum < -INTEG_CLAMP) integ_sum = -INTEG_CLAMP;

    ff = (longint'(spd) * FF_GAIN) >>> 1;
    if (spd > 0) ff = ff + DIR_OFFSET;
    else if (spd < 0) ff = ff - DIR_OFFSET;

    total = prop + (integ_sum >>> INTEG_SHIFT) + deriv + ff;
    // upper limit wins when the limits are inverted
    if (total > longint'(drive_hi)) total = longint'(drive_hi);
    else if (total < longint'(drive_lo)) total = longint'(drive_lo);

    last_err = err;
    return total[DRIVE_W-1:0];
  endfunction

  task automatic report(input string msg);
    if (mismatch_count < PRINT_CAP) $display("drive check: %s", msg);
    mismatch_count++;
  endtask

  // One APB write; psel stays up between writes and drops after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] data,
                           input bit last_one);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (last_one) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    case (idx)
      REG_PROP_GAIN:  kp = data[GAIN_W-1:0];
      REG_INTEG_GAIN: ki = data[GAIN_W-1:0];
      REG_DERIV_GAIN: kd = data[GAIN_W-1:0];
      REG_OUT_UPPER:  drive_hi = data[DRIVE_W-1:0];
      REG_OUT_LOWER:  drive_lo = data[DRIVE_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; unused upper data bits carry junk
  task automatic load_regs(input logic [GAIN_W-1:0] kp_v, ki_v, kd_v,
                           input logic signed [DRIVE_W-1:0] hi_v, lo_v, input bit last_one);
    logic [APB_DW-1:0] junk;
    junk = $urandom;
    write_reg(REG_PROP_GAIN, {junk[APB_DW-1:GAIN_W], kp_v}, 1'b0);
    junk = $urandom;
    write_reg(REG_INTEG_GAIN, {junk[APB_DW-1:GAIN_W], ki_v}, 1'b0);
    junk = $urandom;
    write_reg(REG_DERIV_GAIN, {junk[APB_DW-1:GAIN_W], kd_v}, 1'b0);
    junk = $urandom;
    write_reg(REG_OUT_UPPER, {junk[APB_DW-1:DRIVE_W], hi_v}, 1'b0);
    junk = $urandom;
    write_reg(REG_OUT_LOWER, {junk[APB_DW-1:DRIVE_W], lo_v}, last_one);
  endtask

  // Send one tick after a random gap and log its expected drive on acceptance
  task automatic send_beat(input logic signed [POS_W-1:0] tgt, meas,
                           input logic signed [SPEED_W-1:0] spd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_target_pos   <= tgt;
    in_measured_pos <= meas;
    in_speed_ref    <= spd;
    do @(posedge clk); while (in_stall);
    pending_drive.push_back(predict_drive(tgt, meas, spd));
  endtask

  // Drop valid and hold until every expected drive has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Gains at reset are zero, so only the feedforward and its bias show
  task automatic test_feedforward_only();
    drain();
    send_beat('0, '0, '0);
    send_beat(31'sd500, 31'sd20, 13'sd1);
    send_beat(-31'sd500, 31'sd20, -13'sd1);
    send_beat(POS_MAX, POS_MIN, 13'sd4000);
    send_beat(POS_MIN, POS_MAX, -13'sd4000);
    // speed codes beyond the nominal range
    send_beat('0, '0, 13'sh0FFF);
    send_beat('0, '0, 13'sh1000);
  endtask

  // Full-scale gains against full-scale and tiny errors, with sign flips
  task automatic test_extreme_gains();
    drain();
    load_regs('1, '1, '1, 16'sh7FFF, 16'sh8000, 1'b1);
    send_beat(POS_MAX, POS_MIN, 13'sd4000);
    send_beat(POS_MIN, POS_MAX, -13'sd4000);
    send_beat(POS_MIN, POS_MIN, '0);
    send_beat(POS_MAX, POS_MAX, '0);
    send_beat(31'sd16, '0, '0);
    send_beat(31'sd15, '0, '0);
    send_beat(-31'sd1, '0, '0);
    send_beat(-31'sd17, '0, 13'sd7);
    send_beat('0, POS_MIN, -13'sd7);
  endtask

  // Lower limit above upper limit: the upper limit wins for large sums
  task automatic test_inverted_limits();
    drain();
    load_regs('0, '0, '0, -16'sd100, 16'sd100, 1'b1);
    send_beat('0, '0, 13'sd400);
    send_beat('0, '0, -13'sd400);
    send_beat('0, '0, '0);
  endtask

  // Writes past the register map must leave every register alone
  task automatic test_unmapped_index();
    drain();
    load_regs(15'd16, 15'd4, 15'd1, 16'sd20000, -16'sd20000, 1'b0);
    for (int i = int'(REG_OUT_LOWER) + 1; i <= int'(REG_SLOT_LAST); i++)
      write_reg(3'(i), $urandom, i == int'(REG_SLOT_LAST));
    send_beat(31'sd10, '0, 13'sd100);
    send_beat(-31'sd5, '0, -13'sd50);
    send_beat(31'sd50, 31'sd43, '0);
    send_beat('0, '0, '0);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic signed [DRIVE_W-1:0] pick_limit(input bit upper);
    case ($urandom_range(0, 4))
      0: return upper ? 16'sh7FFF : 16'sh8000;
      1: return DRIVE_W'($urandom);
      default: return upper ? DRIVE_W'($urandom_range(0, 20000))
                            : DRIVE_W'(-int'($urandom_range(0, 20000)));
    endcase
  endfunction

  // Tracking run: the error wanders, flips sign and resets, with some pure noise
  task automatic track_chunk(input int unsigned n);
    longint                    err_walk;
    longint                    meas_v;
    logic signed [POS_W-1:0]   tgt;
    logic signed [POS_W-1:0]   meas;
    logic signed [SPEED_W-1:0] spd;
    int unsigned               scale;
    err_walk = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        tgt  = POS_W'($urandom);
        meas = POS_W'($urandom);
        spd  = SPEED_W'($urandom);
      end else begin
        case ($urandom_range(0, 7))
          0: err_walk = -err_walk;
          1: err_walk = 0;
          2: begin
            scale = $urandom_range(0, 24);
            err_walk = longint'($urandom_range(0, (1 << scale) - 1));
            if ($urandom_range(0, 1) == 1) err_walk = -err_walk;
          end
          default: err_walk = err_walk + longint'($urandom_range(0, 64)) - 32;
        endcase
        if (err_walk > WALK_MAX) err_walk = WALK_MAX;
        if (err_walk < -WALK_MAX) err_walk = -WALK_MAX;
        meas_v = longint'($urandom_range(0, (1 << 30) - 1)) - (1 << 29);
        tgt  = POS_W'(meas_v + err_walk);
        meas = POS_W'(meas_v);
        case ($urandom_range(0, 5))
          0: spd = '0;
          1: spd = SPEED_W'($urandom);
          default: spd = SPEED_W'(int'($urandom_range(0, 8000)) - 4000);
        endcase
      end
      send_beat(tgt, meas, spd);
    end
  endtask

  // Several register settings, extremes first, then random ones
  task automatic test_random_phases();
    logic [GAIN_W-1:0]         kp_v;
    logic [GAIN_W-1:0]         ki_v;
    logic [GAIN_W-1:0]         kd_v;
    logic signed [DRIVE_W-1:0] hi_v;
    logic signed [DRIVE_W-1:0] lo_v;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      kp_v = pick_gain();
      ki_v = pick_gain();
      kd_v = pick_gain();
      hi_v = pick_limit(1'b1);
      lo_v = pick_limit(1'b0);
      if (ph == 0) begin
        kp_v = '0;
        ki_v = '0;
        kd_v = '0;
        hi_v = 16'sh7FFF;
        lo_v = 16'sh8000;
      end else if (ph == 1) begin
        kp_v = '1;
        ki_v = '1;
        kd_v = '1;
        hi_v = 16'sh8000;
        lo_v = 16'sh7FFF;
      end
      load_regs(kp_v, ki_v, kd_v, hi_v, lo_v, 1'b1);
      for (int unsigned b = 0; b < PHASE_BEATS; b += CHUNK_BEATS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        track_chunk(CHUNK_BEATS);
      end
      no_idle = 1'b0;
    end
  endtask

  // Result side: stall for a random count before each beat
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted drive beat with the oldest expectation
  always @(posedge clk) begin
    logic signed [DRIVE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        report($sformatf("drive %0d arrived with nothing pending", out_drive_out));
      end else begin
        want = pending_drive.pop_front();
        if (out_drive_out !== want)
          report($sformatf("drive_out %0d, expected %0d", out_drive_out, want));
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_target_pos   <= '0;
    in_measured_pos <= '0;
    in_speed_ref    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_feedforward_only();
    test_extreme_gains();
    test_inverted_limits();
    test_unmapped_index();
    test_random_phases();
    drain();

    if (mismatch_count == 0 && pending_drive.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
